>>> rtl/core/ffd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffd_pkg
// Shared types, constants and helpers of the form field extract/decode block.
// ----------------------------------------------------------------------------

package ffd_pkg;

  localparam int KEY_MAX_BYTES_DEF   = 8;
  localparam int VALUE_MAX_BYTES_DEF = 64;
  localparam int QUEUE_DEPTH         = 2;
  localparam int RUN_MAX             = 3;

  localparam logic [6:0] MAX_VALUE_LENGTH_RST = 7'd10;

  localparam logic [1:0] CFG_KEY_BYTES        = 2'd0;
  localparam logic [1:0] CFG_KEY_LENGTH       = 2'd1;
  localparam logic [1:0] CFG_MAX_VALUE_LENGTH = 2'd2;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    PH_KEY   = 2'd0,
    PH_VALUE = 2'd1,
    PH_SKIP  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] request_byte;
    logic       request_end;
  } req_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       done_res;
    logic       found;
    logic       last_of_run;
  } res_t;

  // results of one input beat, packed from slot 0
  typedef struct packed {
    logic [1:0]             cnt;
    res_t [RUN_MAX-1:0]     slot;
  } bnd_t;

  // {valid, digit}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic [7:0] plus_to_space(input logic [7:0] c);
    return (c == CH_PLUS) ? CH_SPACE : c;
  endfunction

endpackage

>>> rtl/core/ffd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffd_front
// Config registers, request parser and percent decoder; packs the results of
// each beat into one bundle.
// ----------------------------------------------------------------------------

module ffd_front import ffd_pkg::*; #(
  parameter int KEY_MAX_BYTES   = KEY_MAX_BYTES_DEF,
  parameter int VALUE_MAX_BYTES = VALUE_MAX_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  req_t        req,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [63:0] wr_data,
  input  logic        q_full,
  output logic        bnd_push,
  output bnd_t        bnd
);

  localparam int KB  = KEY_MAX_BYTES * 8;
  localparam int KIW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
  localparam int CW  = $clog2(VALUE_MAX_BYTES);

  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    logic       fnd;
  } evt_t;

  logic [KB-1:0] key_bytes;
  logic [3:0]    key_length;
  logic [6:0]    max_value_length;

  logic [1:0]    sep, sep_next;
  logic          in_body, in_body_next;
  phase_t        phase, phase_next;
  logic [3:0]    kpos, kpos_next;
  logic          kmatch, kmatch_next;
  logic [1:0]    pend, pend_next;
  logic [7:0]    hex1, hex1_next;
  logic [CW-1:0] ecnt, ecnt_next;
  logic          fin, fin_next;

  logic          accept;
  logic [7:0]    b;
  logic [KIW-1:0] kidx;
  logic          key_hit;
  logic [CW-1:0] lim_m1;
  logic [4:0]    d1, d2;
  logic [7:0]    hv;
  evt_t [RUN_MAX-1:0] ev;
  logic [1:0]    ne;
  logic          fin_now;
  logic [CW-1:0] cnt;
  logic [1:0]    nout;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign b      = req.request_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_bytes        <= '0;
      key_length       <= '0;
      max_value_length <= MAX_VALUE_LENGTH_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_KEY_BYTES:        key_bytes        <= wr_data[KB-1:0];
        CFG_KEY_LENGTH:       key_length       <= wr_data[3:0];
        CFG_MAX_VALUE_LENGTH: max_value_length <= wr_data[6:0];
        default: ;
      endcase
    end
  end

  assign kidx    = kpos[KIW-1:0];
  assign key_hit = (kpos < 4'(KEY_MAX_BYTES)) && (key_bytes[8*kidx +: 8] == b);

  always_comb begin
    if (max_value_length == 7'd0) begin
      lim_m1 = '0;
    end else if (max_value_length > 7'(VALUE_MAX_BYTES)) begin
      lim_m1 = CW'(VALUE_MAX_BYTES - 1);
    end else begin
      lim_m1 = CW'(max_value_length - 7'd1);
    end
  end

  assign d1 = hex_digit(hex1);
  assign d2 = hex_digit(b);
  always_comb begin
    if (d1[4] && d2[4]) begin
      hv = {d1[3:0], d2[3:0]};
    end else if (d1[4]) begin
      hv = {4'd0, d1[3:0]};
    end else begin
      hv = 8'd0;
    end
  end

  always_comb begin
    sep_next     = sep;
    in_body_next = in_body;
    phase_next   = phase;
    kpos_next    = kpos;
    kmatch_next  = kmatch;
    pend_next    = pend;
    hex1_next    = hex1;
    ev           = '0;
    ne           = 2'd0;
    fin_now      = 1'b0;

    if (!fin) begin
      if (!in_body) begin
        if (b == CH_CR) begin
          sep_next = (sep == 2'd2) ? 2'd3 : 2'd1;
        end else if (b == CH_LF) begin
          if (sep == 2'd1) begin
            sep_next = 2'd2;
          end else if (sep == 2'd3) begin
            in_body_next = 1'b1;
            sep_next     = 2'd0;
          end else begin
            sep_next = 2'd0;
          end
        end else begin
          sep_next = 2'd0;
        end
      end else begin
        unique case (phase)
          PH_KEY: begin
            if (b == CH_AMP) begin
              kpos_next   = 4'd0;
              kmatch_next = 1'b1;
            end else if (b == CH_EQ) begin
              phase_next = (kmatch && kpos == key_length) ? PH_VALUE : PH_SKIP;
            end else begin
              if (kpos >= key_length || !key_hit) kmatch_next = 1'b0;
              if (kpos != 4'd15) kpos_next = kpos + 4'd1;
            end
          end
          PH_SKIP: begin
            if (b == CH_AMP) begin
              phase_next  = PH_KEY;
              kpos_next   = 4'd0;
              kmatch_next = 1'b1;
            end
          end
          PH_VALUE: begin
            unique case (pend)
              2'd0: begin
                if (b == CH_AMP) begin
                  ev[ne] = '{emit: 1'b0, data: 8'd0, fnd: 1'b1}; ne = ne + 2'd1;
                  fin_now = 1'b1;
                end else if (b == CH_PCT) begin
                  pend_next = 2'd1;
                end else begin
                  ev[ne] = '{emit: 1'b1, data: plus_to_space(b), fnd: 1'b0}; ne = ne + 2'd1;
                end
              end
              2'd1: begin
                if (b == CH_AMP) begin
                  ev[ne] = '{emit: 1'b1, data: CH_PCT, fnd: 1'b0}; ne = ne + 2'd1;
                  ev[ne] = '{emit: 1'b0, data: 8'd0, fnd: 1'b1}; ne = ne + 2'd1;
                  fin_now = 1'b1;
                end else begin
                  hex1_next = b;
                  pend_next = 2'd2;
                end
              end
              default: begin
                if (b == CH_AMP) begin
                  ev[ne] = '{emit: 1'b1, data: CH_PCT, fnd: 1'b0}; ne = ne + 2'd1;
                  ev[ne] = '{emit: 1'b1, data: plus_to_space(hex1), fnd: 1'b0};
                  ne = ne + 2'd1;
                  ev[ne] = '{emit: 1'b0, data: 8'd0, fnd: 1'b1}; ne = ne + 2'd1;
                  fin_now = 1'b1;
                end else begin
                  ev[ne] = '{emit: 1'b1, data: hv, fnd: 1'b0}; ne = ne + 2'd1;
                  pend_next = 2'd0;
                end
              end
            endcase
          end
          default: ;
        endcase
      end

      if (req.request_end && !fin_now) begin
        if (in_body_next && phase_next == PH_VALUE) begin
          if (pend_next == 2'd1) begin
            ev[ne] = '{emit: 1'b1, data: CH_PCT, fnd: 1'b0}; ne = ne + 2'd1;
          end else if (pend_next == 2'd2) begin
            ev[ne] = '{emit: 1'b1, data: CH_PCT, fnd: 1'b0}; ne = ne + 2'd1;
            ev[ne] = '{emit: 1'b1, data: plus_to_space(hex1_next), fnd: 1'b0};
            ne = ne + 2'd1;
          end
          ev[ne] = '{emit: 1'b0, data: 8'd0, fnd: 1'b1}; ne = ne + 2'd1;
        end else begin
          ev[ne] = '{emit: 1'b0, data: 8'd0, fnd: 1'b0}; ne = ne + 2'd1;
        end
        fin_now = 1'b1;
      end
    end
  end

  // drop bytes past the buffer limit, then pack the survivors
  always_comb begin
    cnt  = ecnt;
    nout = 2'd0;
    bnd  = '0;
    for (int i = 0; i < RUN_MAX; i++) begin
      if (2'(i) < ne) begin
        if (ev[i].emit) begin
          if (cnt < lim_m1) begin
            bnd.slot[nout] = '{value_byte: ev[i].data, byte_valid: 1'b1,
                               done_res: 1'b0, found: 1'b0, last_of_run: 1'b0};
            nout = nout + 2'd1;
            cnt  = cnt + CW'(1);
          end
        end else begin
          bnd.slot[nout] = '{value_byte: 8'd0, byte_valid: 1'b0,
                             done_res: 1'b1, found: ev[i].fnd, last_of_run: 1'b0};
          nout = nout + 2'd1;
        end
      end
    end
    if (nout != 2'd0) bnd.slot[nout - 2'd1].last_of_run = 1'b1;
    bnd.cnt   = nout;
    ecnt_next = cnt;
  end

  assign fin_next = fin | fin_now;
  assign bnd_push = accept && (nout != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      sep     <= 2'd0;
      in_body <= 1'b0;
      phase   <= PH_KEY;
      kpos    <= 4'd0;
      kmatch  <= 1'b1;
      pend    <= 2'd0;
      hex1    <= 8'd0;
      ecnt    <= '0;
      fin     <= 1'b0;
    end else if (accept) begin
      if (req.request_end) begin
        sep     <= 2'd0;
        in_body <= 1'b0;
        phase   <= PH_KEY;
        kpos    <= 4'd0;
        kmatch  <= 1'b1;
        pend    <= 2'd0;
        hex1    <= 8'd0;
        ecnt    <= '0;
        fin     <= 1'b0;
      end else begin
        sep     <= sep_next;
        in_body <= in_body_next;
        phase   <= phase_next;
        kpos    <= kpos_next;
        kmatch  <= kmatch_next;
        pend    <= pend_next;
        hex1    <= hex1_next;
        ecnt    <= ecnt_next;
        fin     <= fin_next;
      end
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    bnd_push |-> !q_full)
    else $error("bundle pushed into full queue");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && req.request_end) |=>
      (sep == 2'd0 && !in_body && phase == PH_KEY && ecnt == '0 && !fin && pend == 2'd0))
    else $error("request state not cleared after request end");

  a_cnt_limit: assert property (@(posedge clk) disable iff (rst)
    accept |-> (ecnt_next <= lim_m1 || ecnt_next == ecnt))
    else $error("emitted count passed buffer limit");

endmodule

>>> rtl/core/ffd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffd_queue
// Short bundle queue between parser and result serializer.
// ----------------------------------------------------------------------------

module ffd_queue import ffd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_push,
  input  bnd_t in_bnd,
  output logic is_full,
  input  logic out_pop,
  output bnd_t out_bnd,
  output logic is_empty
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  bnd_t          mem [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [NW-1:0] count;
  logic          do_wr, do_rd;

  assign is_full  = (count == NW'(QUEUE_DEPTH));
  assign is_empty = (count == '0);
  assign do_wr    = in_push && !is_full;
  assign do_rd    = out_pop && !is_empty;
  assign out_bnd  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= in_bnd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (do_rd) rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      if (do_wr && !do_rd) begin
        count <= count + NW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - NW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    in_push |-> !is_full)
    else $error("queue overflow");

endmodule

>>> rtl/core/ffd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffd_back
// Result serializer: holds one bundle and hands out its results one beat at
// a time.
// ----------------------------------------------------------------------------

module ffd_back import ffd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  input  bnd_t q_bnd,
  output logic q_pop,
  output logic empty,
  input  logic pop,
  output res_t res
);

  bnd_t       bnd;
  logic       busy;
  logic [1:0] idx;
  logic       last_beat;
  logic       load;

  assign last_beat = busy && pop && (idx == bnd.cnt - 2'd1);
  assign load      = !q_empty && (!busy || last_beat);
  assign q_pop     = load;
  assign empty     = !busy;
  assign res       = bnd.slot[idx];

  always_ff @(posedge clk) begin
    if (load) bnd <= q_bnd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (last_beat) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (busy && pop) begin
      idx <= idx + 2'd1;
    end
  end

  a_res_kind: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (res.byte_valid || res.done_res))
    else $error("result carries neither byte nor done");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && res.done_res) |-> res.last_of_run)
    else $error("done result not last of its run");

endmodule

>>> rtl/core/form_field_extract_decode_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// form_field_extract_decode_top
// Finds one key in a URL-encoded form body and streams its decoded value.
// ----------------------------------------------------------------------------
//
//   channel   handshake        payload
//   input     push / full      req.request_byte, req.request_end
//   result    pop / empty      res.value_byte, byte_valid, done_res, found,
//                              last_of_run
//   config    wr_en            wr_index, wr_data
//
// One request byte per cycle while full is low; the parser handles it in the
// accept cycle. A byte makes 0 to 3 results, handed out one per cycle by the
// serializer while pop is high, so sustained input rate falls only when result
// beats outnumber input beats. Synchronous reset; no clearing pass. full
// follows the two-entry queue, and the first result of a beat passes through
// the queue and the serializer's bundle register before it reaches the ports.
// ----------------------------------------------------------------------------

module form_field_extract_decode_top import ffd_pkg::*; #(
  parameter int KEY_MAX_BYTES   = KEY_MAX_BYTES_DEF,
  parameter int VALUE_MAX_BYTES = VALUE_MAX_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  req_t        req,
  output logic        empty,
  input  logic        pop,
  output res_t        res,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [63:0] wr_data
);

  logic bnd_push, q_full, q_empty, q_pop;
  bnd_t f_bnd, q_bnd;

  ffd_front #(
    .KEY_MAX_BYTES   (KEY_MAX_BYTES),
    .VALUE_MAX_BYTES (VALUE_MAX_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .req      (req),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .q_full   (q_full),
    .bnd_push (bnd_push),
    .bnd      (f_bnd)
  );

  ffd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_push  (bnd_push),
    .in_bnd   (f_bnd),
    .is_full  (q_full),
    .out_pop  (q_pop),
    .out_bnd  (q_bnd),
    .is_empty (q_empty)
  );

  ffd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_bnd   (q_bnd),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .res     (res)
  );

endmodule
